// ===== hw/rtl/tpac_pkg.sv =====
// tpac_pkg: shared constants, controller state encoding and the
// command / status bundles passed between tpac_ctrl and tpac_dp.
// No dependencies.
`default_nettype none

package tpac_pkg;

	localparam int LINES_DEF      = 8;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int FIELD_BITS     = 32;
	localparam int LINE_BITS      = 3;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CMP   = 7'b0000010,
		ST_SEL   = 7'b0000100,
		ST_WALK  = 7'b0001000,
		ST_FILL  = 7'b0010000,
		ST_TOUCH = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic load_in;
		logic compare;
		logic select;
		logic walk;
		logic fill;
		logic touch;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic any_match;
		logic walk_done;
		logic touch_done;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tree_plru_assoc_cache_unit.sv =====
// Fully associative cache of LINES lines with tree pseudo-LRU replacement.
// Each input beat (key, fill_value) gives one result beat. A key that matches
// a valid line returns that line and its value; otherwise the tree bits pick
// a victim, which takes the key and fill value, and any valid key it held is
// reported as evicted. The tree bits on the accessed line's path then point
// away from it. Valid and tree bits clear at reset. One access is handled at
// a time: load, compare and select, then on a miss a tree walk and a fill,
// then the path update and the result load. A line's leaf lies at most
// ceil(log2(LINES)) levels deep, 3 for eight lines; the tree walk and the
// path update each advance one level per cycle. A finished result waits in
// the output register and blocks the next result, not the next input.
// Depends on tpac_pkg, tpac_ctrl and tpac_dp.
`default_nettype none

module tree_plru_assoc_cache_unit #(
	parameter int LINES      = tpac_pkg::LINES_DEF,
	parameter int KEY_BITS   = tpac_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = tpac_pkg::VALUE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [tpac_pkg::FIELD_BITS-1:0] key,
	input  wire logic [tpac_pkg::FIELD_BITS-1:0] fill_value,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 hit,
	output logic [tpac_pkg::LINE_BITS-1:0]       line,
	output logic [tpac_pkg::FIELD_BITS-1:0]      value_out,
	output logic                                 evicted,
	output logic [tpac_pkg::FIELD_BITS-1:0]      evicted_key
);

	tpac_pkg::dp_cmd_t    cmd;
	tpac_pkg::dp_status_t status;

	tpac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tpac_dp #(
		.LINES      (LINES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.key         (key),
		.fill_value  (fill_value),
		.hit         (hit),
		.line        (line),
		.value_out   (value_out),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && evicted))
		else $error("hit beat reports an eviction");

	a_evkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !evicted) |-> (evicted_key == '0))
		else $error("evicted_key nonzero without eviction");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second beat accepted while access in flight");

	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.compare, cmd.select, cmd.walk, cmd.fill,
			cmd.touch, cmd.load_out}))
		else $error("controller issued overlapping datapath commands");

endmodule

`default_nettype wire

// ===== hw/rtl/tpac_ctrl.sv =====
// tpac_ctrl: sequencing state machine for one cache access at a time.
// Depends on tpac_pkg; drives tpac_dp through dp_cmd_t.
`default_nettype none

module tpac_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	input  wire tpac_pkg::dp_status_t  status,
	output tpac_pkg::dp_cmd_t          cmd
);

	tpac_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == tpac_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			tpac_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = tpac_pkg::ST_CMP;
				end
			end
			tpac_pkg::ST_CMP: begin
				cmd.compare = 1'b1;
				state_d     = tpac_pkg::ST_SEL;
			end
			tpac_pkg::ST_SEL: begin
				cmd.select = 1'b1;
				state_d    = status.any_match ? tpac_pkg::ST_TOUCH : tpac_pkg::ST_WALK;
			end
			tpac_pkg::ST_WALK: begin
				cmd.walk = 1'b1;
				if (status.walk_done) begin
					state_d = tpac_pkg::ST_FILL;
				end
			end
			tpac_pkg::ST_FILL: begin
				cmd.fill = 1'b1;
				state_d  = tpac_pkg::ST_TOUCH;
			end
			tpac_pkg::ST_TOUCH: begin
				cmd.touch = 1'b1;
				if (status.touch_done) begin
					state_d = tpac_pkg::ST_OUT;
				end
			end
			tpac_pkg::ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = tpac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpac_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpac_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tpac_dp.sv =====
// tpac_dp: tag store, valid and tree bits, value memory, victim walk,
// tree update and the result beat register.
// Depends on tpac_pkg; commanded by tpac_ctrl.
`default_nettype none

module tpac_dp #(
	parameter int LINES      = tpac_pkg::LINES_DEF,
	parameter int KEY_BITS   = tpac_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = tpac_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire tpac_pkg::dp_cmd_t                    cmd,
	output tpac_pkg::dp_status_t                      status,
	input  wire logic [tpac_pkg::FIELD_BITS-1:0]      key,
	input  wire logic [tpac_pkg::FIELD_BITS-1:0]      fill_value,
	output logic                                      hit,
	output logic [tpac_pkg::LINE_BITS-1:0]            line,
	output logic [tpac_pkg::FIELD_BITS-1:0]           value_out,
	output logic                                      evicted,
	output logic [tpac_pkg::FIELD_BITS-1:0]           evicted_key
);

	localparam int FB    = tpac_pkg::FIELD_BITS;
	localparam int LB    = tpac_pkg::LINE_BITS;
	localparam int KW    = (KEY_BITS < FB) ? KEY_BITS : FB;
	localparam int VW    = (VALUE_BITS < FB) ? VALUE_BITS : FB;
	localparam int NODES = LINES - 1;
	localparam int IW    = $clog2(LINES);
	localparam int NW    = $clog2(2 * LINES - 1);
	localparam int TW    = (NODES > 1) ? $clog2(NODES) : 1;

	logic [KW-1:0]    key_q;
	logic [VW-1:0]    val_q;
	logic [KW-1:0]    keys_q [LINES];
	logic [LINES-1:0] valid_q;
	logic [NODES-1:0] tree_q;
	logic [VW-1:0]    val_mem [LINES];
	logic [VW-1:0]    rd_q;
	logic [LINES-1:0] match_q;
	logic [IW-1:0]    idx_q;
	logic [NW-1:0]    node_q;
	logic [NW-1:0]    leaf_q;
	logic             hit_q;
	logic             ev_q;
	logic [KW-1:0]    ev_key_q;

	logic [IW-1:0]    first_idx;
	logic [NW:0]      node_next;
	logic [NW-1:0]    node_off;
	logic [NW-1:0]    leaf_m1;
	logic [NW-1:0]    parent;

	// lowest matching line
	always_comb begin
		first_idx = '0;
		for (int i = LINES - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				first_idx = IW'(i);
			end
		end
	end

	assign node_next = {node_q, 1'b0} + ((NW + 1)'(tree_q[node_q[TW-1:0]] ? 2 : 1));
	assign node_off  = node_q - NW'(NODES);
	assign leaf_m1   = leaf_q - NW'(1);
	assign parent    = leaf_m1 >> 1;

	assign status.any_match  = |match_q;
	assign status.walk_done  = (node_q >= NW'(NODES));
	assign status.touch_done = (leaf_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			tree_q  <= '0;
		end else begin
			if (cmd.fill) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (cmd.touch && !status.touch_done) begin
				tree_q[parent[TW-1:0]] <= leaf_q[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			key_q <= key[KW-1:0];
			val_q <= fill_value[VW-1:0];
		end
		if (cmd.compare) begin
			for (int i = 0; i < LINES; i++) begin
				match_q[i] <= valid_q[i] && (keys_q[i] == key_q);
			end
		end
		if (cmd.select) begin
			hit_q    <= status.any_match;
			ev_q     <= 1'b0;
			ev_key_q <= '0;
			node_q   <= '0;
			if (status.any_match) begin
				idx_q  <= first_idx;
				leaf_q <= NW'(first_idx) + NW'(NODES);
			end
		end
		if (cmd.walk) begin
			if (status.walk_done) begin
				idx_q <= node_off[IW-1:0];
			end else begin
				node_q <= node_next[NW-1:0];
			end
		end
		if (cmd.fill) begin
			keys_q[idx_q] <= key_q;
			ev_q          <= valid_q[idx_q];
			ev_key_q      <= valid_q[idx_q] ? keys_q[idx_q] : '0;
			leaf_q        <= NW'(idx_q) + NW'(NODES);
		end
		if (cmd.touch && !status.touch_done) begin
			leaf_q <= parent;
		end
		if (cmd.load_out) begin
			hit         <= hit_q;
			line        <= LB'(idx_q);
			value_out   <= FB'(rd_q);
			evicted     <= ev_q;
			evicted_key <= FB'(ev_key_q);
		end
	end

	// value store, registered read
	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			val_mem[idx_q] <= val_q;
		end
		rd_q <= val_mem[idx_q];
	end

endmodule

`default_nettype wire

// ===== verif/tpac_checker.sv =====
// tpac_checker: watches both channels of tree_plru_assoc_cache_unit, keeps its own
// copy of the cache lines and replacement tree, and checks every result beat.
// Depends on tpac_pkg.

module tpac_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [tpac_pkg::FIELD_BITS-1:0] key,
	input  logic [tpac_pkg::FIELD_BITS-1:0] fill_value,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            hit,
	input  logic [tpac_pkg::LINE_BITS-1:0]  line,
	input  logic [tpac_pkg::FIELD_BITS-1:0] value_out,
	input  logic                            evicted,
	input  logic [tpac_pkg::FIELD_BITS-1:0] evicted_key,
	output int                              fail_count,
	output int                              pending,
	output int                              checked,
	output int                              hits,
	output int                              evictions
);

	localparam int LINES = tpac_pkg::LINES_DEF;
	localparam int NODES = LINES - 1;

	typedef struct packed {
		logic                            hit;
		logic [tpac_pkg::LINE_BITS-1:0]  line;
		logic [tpac_pkg::FIELD_BITS-1:0] value;
		logic                            evicted;
		logic [tpac_pkg::FIELD_BITS-1:0] evicted_key;
	} access_result_t;

	logic [NODES-1:0]                plru_tree;
	logic [LINES-1:0]                line_valid;
	logic [tpac_pkg::FIELD_BITS-1:0] line_keys [LINES];
	logic [tpac_pkg::FIELD_BITS-1:0] line_values [LINES];
	access_result_t                  expected_results [$];

	function automatic access_result_t lookup_and_fill(
		input logic [tpac_pkg::FIELD_BITS-1:0] k,
		input logic [tpac_pkg::FIELD_BITS-1:0] v
	);
		access_result_t r;
		logic found;
		int idx;
		int node;
		int leaf;
		int parent;
		r = '0;
		found = 1'b0;
		idx = 0;
		for (int i = 0; i < LINES; i++) begin
			if (!found && line_valid[i] && line_keys[i] == k) begin
				found = 1'b1;
				idx = i;
			end
		end
		if (!found) begin
			node = 0;
			while (node < NODES)
				node = plru_tree[node] ? 2 * node + 2 : 2 * node + 1;
			idx = node - NODES;
			if (line_valid[idx]) begin
				r.evicted = 1'b1;
				r.evicted_key = line_keys[idx];
			end
			line_keys[idx] = k;
			line_values[idx] = v;
			line_valid[idx] = 1'b1;
		end
		// point every node on the path away from the accessed line
		leaf = idx + NODES;
		while (leaf > 0) begin
			parent = (leaf - 1) / 2;
			plru_tree[parent] = (leaf == 2 * parent + 1);
			leaf = parent;
		end
		r.hit = found;
		r.line = idx[tpac_pkg::LINE_BITS-1:0];
		r.value = line_values[idx];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		access_result_t exp_r;
		if (!arst_n) begin
			plru_tree = '0;
			line_valid = '0;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
			hits = 0;
			evictions = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no access outstanding");
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					checked++;
					if (hit !== exp_r.hit) begin
						$error("hit: expected %0d, got %0d", exp_r.hit, hit);
						fail_count++;
					end
					if (line !== exp_r.line) begin
						$error("line: expected %0d, got %0d", exp_r.line, line);
						fail_count++;
					end
					if (value_out !== exp_r.value) begin
						$error("value_out: expected %h, got %h", exp_r.value, value_out);
						fail_count++;
					end
					if (evicted !== exp_r.evicted) begin
						$error("evicted: expected %0d, got %0d", exp_r.evicted, evicted);
						fail_count++;
					end
					if (evicted_key !== exp_r.evicted_key) begin
						$error("evicted_key: expected %h, got %h", exp_r.evicted_key,
							evicted_key);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				exp_r = lookup_and_fill(key, fill_value);
				expected_results.push_back(exp_r);
				if (exp_r.hit)
					hits++;
				if (exp_r.evicted)
					evictions++;
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// tb_top: drives directed and random accesses into tree_plru_assoc_cache_unit
// under three idling mixes and gives the verdict from tpac_checker.
// Depends on tpac_pkg, the cache unit RTL and tpac_checker.

module tb_top;

	localparam int POOL_KEYS = 12;
	localparam int RANDOM_PER_PHASE = 367;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [tpac_pkg::FIELD_BITS-1:0] key = '0;
	logic [tpac_pkg::FIELD_BITS-1:0] fill_value = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic                            hit;
	logic [tpac_pkg::LINE_BITS-1:0]  line;
	logic [tpac_pkg::FIELD_BITS-1:0] value_out;
	logic                            evicted;
	logic [tpac_pkg::FIELD_BITS-1:0] evicted_key;

	int fail_count;
	int pending;
	int checked;
	int hits;
	int evictions;
	int tx_idle_pct = 28;
	int rx_idle_pct = 77;
	int sent = 0;

	logic [tpac_pkg::FIELD_BITS-1:0] key_pool [POOL_KEYS];

	tree_plru_assoc_cache_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.key         (key),
		.fill_value  (fill_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.line        (line),
		.value_out   (value_out),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

	tpac_checker cache_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.key         (key),
		.fill_value  (fill_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.line        (line),
		.value_out   (value_out),
		.evicted     (evicted),
		.evicted_key (evicted_key),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked),
		.hits        (hits),
		.evictions   (evictions)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n)
			out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_access(input logic [31:0] k, input logic [31:0] v);
		int gap;
		gap = 0;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		key <= k;
		fill_value <= v;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic random_accesses(input int count);
		logic [31:0] k;
		logic [31:0] v;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(49) == 0)
				key_pool[$urandom_range(POOL_KEYS - 1)] = $urandom;
			k = ($urandom_range(99) < 80) ? key_pool[$urandom_range(POOL_KEYS - 1)] : $urandom;
			case ($urandom_range(9))
				0: v = '0;
				1: v = '1;
				default: v = $urandom;
			endcase
			send_access(k, v);
		end
	endtask

	initial begin
		int guard;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill every line from empty, including the all-zero and all-one keys
		send_access(32'h0000_0000, 32'h0000_0000);
		send_access(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_access(32'h0000_0001, 32'h1234_5678);
		send_access(32'h8000_0000, 32'h8000_0001);
		send_access(32'h5555_5555, 32'hAAAA_AAAA);
		send_access(32'hAAAA_AAAA, 32'h5555_5555);
		send_access(32'h0000_FFFF, 32'hFFFF_0000);
		send_access(32'hFFFF_0000, 32'h0000_FFFF);
		// hits ignore the fill value
		send_access(32'h0000_0000, 32'hFFFF_FFFF);
		send_access(32'hFFFF_FFFF, 32'h0000_0000);
		send_access(32'h5555_5555, 32'h0F0F_0F0F);
		// misses on a full cache evict
		send_access(32'h1357_9BDF, 32'hDEAD_BEEF);
		send_access(32'h2468_ACE0, 32'hCAFE_F00D);
		send_access(32'h0000_0001, 32'h7777_7777);
		send_access(32'h1357_9BDF, 32'h0000_0000);
		send_access(32'h8000_0000, 32'hFFFF_FFFF);
		send_access(32'h7FFF_FFFF, 32'h8000_0000);
		send_access(32'hFFFF_FFFE, 32'h0000_0001);
		send_access(32'h0000_0000, 32'h1111_1111);
		send_access(32'hFFFF_FFFF, 32'h2222_2222);

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_KEYS; i++)
			key_pool[i] = $urandom;

		random_accesses(RANDOM_PER_PHASE);
		tx_idle_pct = 77;
		rx_idle_pct = 28;
		random_accesses(RANDOM_PER_PHASE);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_accesses(RANDOM_PER_PHASE);
		in_valid <= 1'b0;

		guard = 0;
		while (pending != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (40) @(negedge clk);

		$display("%0d accesses sent, %0d results checked: %0d hits, %0d misses, %0d evictions",
			sent, checked, hits, checked - hits, evictions);
		if (pending != 0)
			$error("%0d results never arrived", pending);
		if (fail_count == 0 && pending == 0) begin
			$display("tree_plru_assoc_cache_unit test passed");
		end else begin
			$display("tree_plru_assoc_cache_unit test failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tree_plru_assoc_cache_unit test failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/tpac_pkg.sv
hw/rtl/tpac_ctrl.sv
hw/rtl/tpac_dp.sv
hw/rtl/tree_plru_assoc_cache_unit.sv
verif/tpac_checker.sv
verif/tb_top.sv
